/* src/pidt_pkg.sv */
// Shared constants, types and saturation helper for the timestamped PID unit.
// No dependencies; the channel file and the top level refer to it by scoped names.
package pidt_pkg;

  localparam int Q_W        = 32;
  localparam int SETPOINT_W = 16;
  localparam int CFG_IDX_W  = 8;
  localparam int CFG_DATA_W = 32;
  localparam int TICK_MAX_W = 64;

  // Register indexes of the configuration port.
  localparam logic [CFG_IDX_W-1:0] CFG_SETPOINT = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_P   = 8'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_I   = 8'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_D   = 8'd3;

  // Wide signed working width; holds any magnitude the serial units produce plus a sign.
  localparam int WIDE_W = 68;

  localparam logic signed [WIDE_W-1:0] Q_MAX_WIDE =
    {{(WIDE_W-Q_W+1){1'b0}}, {(Q_W-1){1'b1}}};
  localparam logic signed [WIDE_W-1:0] Q_MIN_WIDE =
    {{(WIDE_W-Q_W+1){1'b1}}, {(Q_W-1){1'b0}}};
  localparam logic [WIDE_W-1:0] INCR_A_LIMIT = WIDE_W'(64'h0000_0000_8000_0000);
  localparam logic [WIDE_W-1:0] INCR_LIMIT   = WIDE_W'(64'h0000_0002_0000_0000);

  typedef struct packed {
    logic [Q_W-1:0] value;
    logic           clip;
  } sat_t;

  function automatic sat_t sat_q(input logic signed [WIDE_W-1:0] v);
    sat_t r;
    if (v > Q_MAX_WIDE) begin
      r.value = Q_MAX_WIDE[Q_W-1:0];
      r.clip  = 1'b1;
    end else if (v < Q_MIN_WIDE) begin
      r.value = Q_MIN_WIDE[Q_W-1:0];
      r.clip  = 1'b1;
    end else begin
      r.value = v[Q_W-1:0];
      r.clip  = 1'b0;
    end
    return r;
  endfunction

endpackage

/* src/pidt_ifs.sv */
// Request channels of the timestamped PID unit: sample input and result output.
// Depends on pidt_pkg for the fixed Q16.16 width.
interface pidt_sample_if #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TICK_WIDTH   = 32
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] measurement;
  logic        [TICK_WIDTH-1:0]   tick_now;

  modport source (output valid, output measurement, output tick_now, input ready);
  modport sink   (input valid, input measurement, input tick_now, output ready);
endinterface

interface pidt_result_if;
  logic                             valid;
  logic                             ready;
  logic signed [pidt_pkg::Q_W-1:0]  drive;
  logic signed [pidt_pkg::Q_W-1:0]  p_term;
  logic signed [pidt_pkg::Q_W-1:0]  i_term;
  logic signed [pidt_pkg::Q_W-1:0]  d_term;
  logic                             saturated;

  modport source (output valid, output drive, output p_term, output i_term,
                  output d_term, output saturated, input ready);
  modport sink   (input valid, input drive, input p_term, input i_term,
                  input d_term, input saturated, output ready);
endinterface

/* src/pidt_sermul.sv */
// Bit-serial unsigned shift-add multiplier: one multiplier bit per step.
// Standalone; the product is valid after B_W steps following start.
module pidt_sermul #(
  parameter int A_W = 32,
  parameter int B_W = 17
) (
  input  logic               clk,
  input  logic               start,
  input  logic               step,
  input  logic [A_W-1:0]     a,
  input  logic [B_W-1:0]     b,
  output logic [A_W+B_W-1:0] prod
);

  logic [A_W-1:0] mcand;
  logic [A_W-1:0] hi;
  logic [B_W-1:0] lo;
  logic [A_W:0]   sum;

  assign sum  = {1'b0, hi} + (lo[0] ? {1'b0, mcand} : '0);
  assign prod = {hi, lo};

  // The multiplier bits leave the low end as product bits fill in from the top.
  always_ff @(posedge clk) begin
    if (start) begin
      mcand <= a;
      hi    <= '0;
      lo    <= b;
    end else if (step) begin
      hi <= sum[A_W:1];
      lo <= {sum[0], lo[B_W-1:1]};
    end
  end

endmodule

/* src/pidt_serdiv.sv */
// Restoring radix-2 divider: one quotient bit per step.
// Standalone; the quotient is valid after N_W steps following start.
module pidt_serdiv #(
  parameter int N_W = 49,
  parameter int D_W = 32
) (
  input  logic           clk,
  input  logic           start,
  input  logic           step,
  input  logic [N_W-1:0] num,
  input  logic [D_W-1:0] den,
  output logic [N_W-1:0] quot
);

  logic [N_W-1:0] q;
  logic [D_W-1:0] rem;
  logic [D_W-1:0] dvs;
  logic [D_W:0]   trial;
  logic [D_W:0]   diff;
  logic           fits;

  assign trial = {rem, q[N_W-1]};
  assign diff  = trial - {1'b0, dvs};
  assign fits  = (trial >= {1'b0, dvs});
  assign quot  = q;

  // Dividend bits shift out of the top while quotient bits enter at the bottom.
  always_ff @(posedge clk) begin
    if (start) begin
      q   <= num;
      rem <= '0;
      dvs <= den;
    end else if (step) begin
      q   <= {q[N_W-2:0], fits};
      rem <= fits ? diff[D_W-1:0] : trial[D_W-1:0];
    end
  end

endmodule

/* src/pid_controller_timestamped_unit.sv */
// Top level of the timestamped Q16.16 PID unit: configuration, sequencer, term assembly.
// Depends on pidt_pkg, pidt_ifs (channels), pidt_sermul and pidt_serdiv.
//
// Usage: configure setpoint and gains through cfg_write/cfg_index/cfg_data while the
// unit is idle. Each request on sample_in carries a measurement and the current tick
// count; the unit answers with one request on result_out holding drive, the three
// terms and a saturation flag.
// Sequence, with EW = max(SAMPLE_WIDTH, 16) + 1 and NW = 32 + EW:
//   the three products run bit-serially in parallel over the EW-bit magnitudes, then the
//   NW-bit derivative quotient comes out of the radix-2 divider (the integral time product
//   runs alongside it), then the term, integral, total and output steps assemble and
//   saturate the terms and hand on the result. One sample is in flight at a time, so a
//   new sample is taken only after the previous one has left the output step.
// The result sits in an output register: the next sample is taken while it waits.
// If the receiver stalls longer, the finished item waits in its last step and the
// integral, previous sample and previous tick are committed only when it moves out.
// Reset clears the configuration, the integral, the previous sample and tick, and
// drops both valid and any work in progress.
module pid_controller_timestamped_unit #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int TICK_WIDTH   = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [pidt_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [pidt_pkg::CFG_DATA_W-1:0]    cfg_data,
  pidt_sample_if.sink                        sample_in,
  pidt_result_if.source                      result_out
);

  localparam int QW    = pidt_pkg::Q_W;
  localparam int WW    = pidt_pkg::WIDE_W;
  localparam int EW    = ((SAMPLE_WIDTH > pidt_pkg::SETPOINT_W) ? SAMPLE_WIDTH
                                                               : pidt_pkg::SETPOINT_W) + 1;
  localparam int DFW   = SAMPLE_WIDTH + 1;
  localparam int PW    = QW + EW;
  localparam int CNT_W = $clog2(PW + 1);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_PREP  = 4'd1;
  localparam logic [3:0] ST_MUL   = 4'd2;
  localparam logic [3:0] ST_LOAD2 = 4'd3;
  localparam logic [3:0] ST_DIV   = 4'd4;
  localparam logic [3:0] ST_TERM  = 4'd5;
  localparam logic [3:0] ST_INTEG = 4'd6;
  localparam logic [3:0] ST_TOTAL = 4'd7;
  localparam logic [3:0] ST_OUT   = 4'd8;

  // Configuration and persistent controller state.
  logic signed [pidt_pkg::SETPOINT_W-1:0] setpoint;
  logic signed [QW-1:0]                   gain_p;
  logic signed [QW-1:0]                   gain_i_per_tick;
  logic signed [QW-1:0]                   gain_d_ticks;
  logic signed [QW-1:0]                   integral_acc;
  logic signed [SAMPLE_WIDTH-1:0]         prev_meas;
  logic        [TICK_WIDTH-1:0]           prev_tick;

  logic [3:0]       state;
  logic [3:0]       state_next;
  logic [CNT_W-1:0] cnt;
  logic [CNT_W-1:0] cnt_next;
  logic             out_valid;
  logic             accept;
  logic             out_free;

  // Per-item working registers.
  logic                           err_neg;
  logic [EW-1:0]                  err_mag;
  logic                           diff_neg;
  logic [EW-1:0]                  diff_mag;
  logic [TICK_WIDTH-1:0]          dt;
  logic signed [SAMPLE_WIDTH-1:0] meas_r;
  logic [TICK_WIDTH-1:0]          tick_r;
  logic signed [QW-1:0]           p_r;
  logic signed [QW-1:0]           d_r;
  logic signed [QW-1:0]           i_r;
  logic signed [QW-1:0]           sum_r;
  logic                           p_clip;
  logic                           d_clip;
  logic                           i_clip;
  logic                           s_clip;
  logic signed [WW-1:0]           incr_r;

  logic signed [QW-1:0]           drive_q;
  logic signed [QW-1:0]           p_q;
  logic signed [QW-1:0]           i_q;
  logic signed [QW-1:0]           d_q;
  logic                           sat_q;

  // Combinational capture and assembly.
  logic signed [EW-1:0]           err_x;
  logic signed [DFW-1:0]          diff_x;
  logic [DFW-1:0]                 diff_abs;
  logic [QW-1:0]                  kp_mag;
  logic [QW-1:0]                  ki_mag;
  logic [QW-1:0]                  kd_mag;
  logic [PW-1:0]                  prod_p;
  logic [PW-1:0]                  prod_i;
  logic [PW-1:0]                  prod_d;
  logic [2*QW-1:0]                prod_it;
  logic [PW-1:0]                  quot;
  logic [pidt_pkg::TICK_MAX_W-1:0] dt_wide;
  logic                           dt_zero;
  logic                           mul_start;
  logic                           mul_step;
  logic                           ph2_start;
  logic                           div_step;
  logic                           it_step;
  logic signed [WW-1:0]           p_wide;
  logic signed [WW-1:0]           d_wide;
  logic [WW-1:0]                  a_mag;
  logic [WW-1:0]                  it_clip;
  logic [WW-1:0]                  incr_mag;
  logic signed [WW-1:0]           i_wide;
  logic signed [WW-1:0]           s_wide;
  pidt_pkg::sat_t                 p_sat;
  pidt_pkg::sat_t                 d_sat;
  pidt_pkg::sat_t                 i_sat;
  pidt_pkg::sat_t                 s_sat;

  assign accept   = sample_in.valid && sample_in.ready;
  assign out_free = !out_valid || result_out.ready;

  assign sample_in.ready      = (state == ST_IDLE);
  assign result_out.valid     = out_valid;
  assign result_out.drive     = drive_q;
  assign result_out.p_term    = p_q;
  assign result_out.i_term    = i_q;
  assign result_out.d_term    = d_q;
  assign result_out.saturated = sat_q;

  assign err_x    = EW'(setpoint) - EW'(sample_in.measurement);
  assign diff_x   = DFW'(prev_meas) - DFW'(sample_in.measurement);
  assign diff_abs = diff_x[DFW-1] ? DFW'(-diff_x) : DFW'(diff_x);

  assign kp_mag = gain_p[QW-1]          ? QW'(-gain_p)          : QW'(gain_p);
  assign ki_mag = gain_i_per_tick[QW-1] ? QW'(-gain_i_per_tick) : QW'(gain_i_per_tick);
  assign kd_mag = gain_d_ticks[QW-1]    ? QW'(-gain_d_ticks)    : QW'(gain_d_ticks);

  assign dt_wide = pidt_pkg::TICK_MAX_W'(dt);
  assign dt_zero = (dt == '0);

  assign mul_start = (state == ST_PREP);
  assign mul_step  = (state == ST_MUL);
  assign ph2_start = (state == ST_LOAD2);
  assign div_step  = (state == ST_DIV);
  assign it_step   = div_step && (cnt < CNT_W'(QW));

  pidt_sermul #(.A_W(QW), .B_W(EW)) u_mul_p (
    .clk(clk), .start(mul_start), .step(mul_step),
    .a(kp_mag), .b(err_mag), .prod(prod_p)
  );

  pidt_sermul #(.A_W(QW), .B_W(EW)) u_mul_i (
    .clk(clk), .start(mul_start), .step(mul_step),
    .a(ki_mag), .b(err_mag), .prod(prod_i)
  );

  pidt_sermul #(.A_W(QW), .B_W(EW)) u_mul_d (
    .clk(clk), .start(mul_start), .step(mul_step),
    .a(kd_mag), .b(diff_mag), .prod(prod_d)
  );

  // Integral increment magnitude times elapsed ticks; only meaningful when both fit 32 bits.
  pidt_sermul #(.A_W(QW), .B_W(QW)) u_mul_it (
    .clk(clk), .start(ph2_start), .step(it_step),
    .a(prod_i[QW-1:0]), .b(dt_wide[QW-1:0]), .prod(prod_it)
  );

  pidt_serdiv #(.N_W(PW), .D_W(TICK_WIDTH)) u_div (
    .clk(clk), .start(ph2_start), .step(div_step),
    .num(prod_d), .den(dt), .quot(quot)
  );

  always_comb begin
    p_wide = $signed(WW'(prod_p));
    if (err_neg ^ gain_p[QW-1]) begin
      p_wide = -p_wide;
    end
    p_sat = pidt_pkg::sat_q(p_wide);

    d_wide = $signed(WW'(quot));
    if (diff_neg ^ gain_d_ticks[QW-1]) begin
      d_wide = -d_wide;
    end
    d_sat = pidt_pkg::sat_q(d_wide);

    // The increment is clipped to 2^33 in magnitude before it reaches the accumulator.
    a_mag   = WW'(prod_i);
    it_clip = (WW'(prod_it) > pidt_pkg::INCR_LIMIT) ? pidt_pkg::INCR_LIMIT : WW'(prod_it);
    if ((a_mag == '0) || dt_zero) begin
      incr_mag = '0;
    end else if ((a_mag > pidt_pkg::INCR_A_LIMIT) || (dt_wide[pidt_pkg::TICK_MAX_W-1:QW] != '0)) begin
      incr_mag = pidt_pkg::INCR_LIMIT;
    end else begin
      incr_mag = it_clip;
    end

    i_wide = WW'(integral_acc) + incr_r;
    i_sat  = pidt_pkg::sat_q(i_wide);

    s_wide = WW'(p_r) + WW'(i_r) + WW'(d_r);
    s_sat  = pidt_pkg::sat_q(s_wide);
  end

  always_comb begin
    state_next = state;
    cnt_next   = cnt;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_PREP;
        end
      end
      ST_PREP: begin
        state_next = ST_MUL;
        cnt_next   = '0;
      end
      ST_MUL: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(EW - 1)) begin
          state_next = ST_LOAD2;
        end
      end
      ST_LOAD2: begin
        state_next = ST_DIV;
        cnt_next   = '0;
      end
      ST_DIV: begin
        cnt_next = cnt + 1'b1;
        if (cnt == CNT_W'(PW - 1)) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM:  state_next = ST_INTEG;
      ST_INTEG: state_next = ST_TOTAL;
      ST_TOTAL: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cnt             <= '0;
      out_valid       <= 1'b0;
      setpoint        <= '0;
      gain_p          <= '0;
      gain_i_per_tick <= '0;
      gain_d_ticks    <= '0;
      integral_acc    <= '0;
      prev_meas       <= '0;
      prev_tick       <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      if (cfg_write) begin
        case (cfg_index)
          pidt_pkg::CFG_SETPOINT: setpoint        <= cfg_data[pidt_pkg::SETPOINT_W-1:0];
          pidt_pkg::CFG_GAIN_P:   gain_p          <= cfg_data[QW-1:0];
          pidt_pkg::CFG_GAIN_I:   gain_i_per_tick <= cfg_data[QW-1:0];
          pidt_pkg::CFG_GAIN_D:   gain_d_ticks    <= cfg_data[QW-1:0];
          default: ;
        endcase
      end
      if ((state == ST_OUT) && out_free) begin
        out_valid    <= 1'b1;
        integral_acc <= i_r;
        prev_meas    <= meas_r;
        prev_tick    <= tick_r;
      end else if (result_out.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      err_neg  <= err_x[EW-1];
      err_mag  <= err_x[EW-1] ? EW'(-err_x) : EW'(err_x);
      diff_neg <= diff_x[DFW-1];
      diff_mag <= EW'(diff_abs);
      dt       <= sample_in.tick_now - prev_tick;
      meas_r   <= sample_in.measurement;
      tick_r   <= sample_in.tick_now;
    end
    if (state == ST_TERM) begin
      p_r    <= p_sat.value;
      p_clip <= p_sat.clip;
      d_r    <= dt_zero ? '0 : d_sat.value;
      d_clip <= dt_zero ? 1'b0 : d_sat.clip;
      incr_r <= (err_neg ^ gain_i_per_tick[QW-1]) ? -$signed(incr_mag) : $signed(incr_mag);
    end
    if (state == ST_INTEG) begin
      i_r    <= i_sat.value;
      i_clip <= i_sat.clip;
    end
    if (state == ST_TOTAL) begin
      sum_r  <= s_sat.value;
      s_clip <= s_sat.clip;
    end
    if ((state == ST_OUT) && out_free) begin
      drive_q <= sum_r;
      p_q     <= p_r;
      i_q     <= i_r;
      d_q     <= d_r;
      sat_q   <= p_clip | d_clip | i_clip | s_clip;
    end
  end

  // A taken sample always starts the serial products on the next cycle.
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state == ST_PREP))
    else $error("accepted sample did not start the multipliers");

  // A new result appears only out of the final assembly step.
  a_result_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_OUT))
    else $error("result valid rose outside the output step");

  // The integral is committed only when a result moves into the output register.
  a_integral_commit: assert property (@(posedge clk) disable iff (rst)
    (!$past(rst) && !$stable(integral_acc)) |-> ($past(state) == ST_OUT))
    else $error("integral changed outside a result commit");

  // No elapsed ticks means no derivative contribution.
  a_d_zero: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_TOTAL) && dt_zero) |-> (d_r == '0))
    else $error("derivative nonzero with zero elapsed ticks");

endmodule
